@@ src/ltpps_pkg.sv @@
// ----------------------------------------------------------------------------
// ltpps_pkg: shared types and constants for the line time stamp block
// Item layouts, command and status codes, store sizing.
// ----------------------------------------------------------------------------
package ltpps_pkg;

    // store sizing
    localparam int MAX_LINES = 1024;
    localparam int IDX_W     = $clog2(MAX_LINES);
    localparam int CNT_W     = IDX_W + 1;

    // header constants
    localparam logic [15:0] PPS_MARK = 16'hBABE;

    // command codes of an input item
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // status codes of a result item
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_MARKER = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] sys_time_raw;
        logic [15:0] status_raw;
        logic [31:0] tow_raw;
        logic [31:0] pps_raw;
        logic        header_complete;
    } in_item_t;

    typedef struct packed {
        logic signed [36:0] timestamp;
        logic               is_last;
        logic [1:0]         status;
        logic               overflowed;
    } out_item_t;

    // one stored line
    typedef struct packed {
        logic [31:0] internal;
        logic [31:0] tow;
        logic [31:0] pps;
    } line_rec_t;

    localparam int REC_W = $bits(line_rec_t);

    // classified operation passed from front to back
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t       op;
        line_rec_t rec;
        logic      marker;
    } q_item_t;

endpackage

@@ src/ltpps_ram.sv @@
// ----------------------------------------------------------------------------
// ltpps_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ltpps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ltpps_front.sv @@
// ----------------------------------------------------------------------------
// ltpps_front: input side of the line time stamp block
// Accepts items, decodes the header words and queues the operation.
// ----------------------------------------------------------------------------
module ltpps_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ltpps_pkg::in_item_t  in_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output ltpps_pkg::q_item_t   q_item
);

    function automatic logic [31:0] byte_reverse(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] swap_halves(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    ltpps_pkg::q_item_t entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    ltpps_pkg::q_item_t cls;
    logic               push;
    logic               known;

    // classify the incoming item
    always_comb
    begin
        cls        = '0;
        known      = 1'b1;
        case (in_data.command)
            ltpps_pkg::CMD_CLEAR: cls.op = ltpps_pkg::OP_CLEAR;
            ltpps_pkg::CMD_LOAD:  cls.op = ltpps_pkg::OP_LOAD;
            ltpps_pkg::CMD_READ:  cls.op = ltpps_pkg::OP_READ;
            default:
            begin
                cls.op = ltpps_pkg::OP_CLEAR;
                known  = 1'b0;
            end
        endcase
        if (in_data.header_complete)
        begin
            cls.rec.internal = in_data.sys_time_raw;
            cls.rec.tow      = byte_reverse(in_data.tow_raw);
            cls.rec.pps      = swap_halves(in_data.pps_raw);
            cls.marker       = (in_data.status_raw == ltpps_pkg::PPS_MARK);
        end
    end

    // two-entry queue; unused commands are accepted and dropped
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && known;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ src/ltpps_back.sv @@
// ----------------------------------------------------------------------------
// ltpps_back: execution side of the line time stamp block
// Runs clear, load and read operations against the line and marker stores.
// ----------------------------------------------------------------------------
module ltpps_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  ltpps_pkg::q_item_t   q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ltpps_pkg::out_item_t out_data
);

    localparam int IW = ltpps_pkg::IDX_W;
    localparam int CW = ltpps_pkg::CNT_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MARK_A = 7'b0000010,
        ST_SEL    = 7'b0000100,
        ST_LINE_I = 7'b0001000,
        ST_LINE_R = 7'b0010000,
        ST_CALC   = 7'b0100000,
        ST_MARK_B = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        line_count_reg, line_count_next;
    logic [CW-1:0]        marker_count_reg, marker_count_next;
    logic [CW-1:0]        read_index_reg, read_index_next;
    logic [IW-1:0]        marker_pos_reg, marker_pos_next;
    logic [IW-1:0]        prev_reg, prev_next;
    logic [IW-1:0]        next_marker_reg, next_marker_next;
    logic                 overflow_reg, overflow_next;
    logic                 first_reg, first_next;
    logic [IW-1:0]        ref_reg, ref_next;
    logic [31:0]          internal_reg, internal_next;
    logic [35:0]          tow10_reg, tow10_next;
    logic [32:0]          diff_reg, diff_next;
    logic                 out_valid_reg, out_valid_next;
    ltpps_pkg::out_item_t out_reg, out_next;

    logic                 line_we, line_re, mk_we, mk_re;
    logic [IW-1:0]        line_waddr, line_raddr, mk_waddr, mk_raddr, mk_wdata, mk_rdata;
    logic [ltpps_pkg::REC_W-1:0] line_wdata, line_rdata;
    ltpps_pkg::line_rec_t line_rd;

    logic [IW-1:0]        idx;
    logic [IW-1:0]        dist_prev, dist_next;
    logic                 more_markers;
    logic [36:0]          stamp;

    assign line_rd      = ltpps_pkg::line_rec_t'(line_rdata);
    assign idx          = read_index_reg[IW-1:0];
    assign more_markers = ({1'b0, marker_pos_reg} + CW'(1)) < marker_count_reg;
    assign dist_prev    = (idx > prev_reg) ? idx - prev_reg : prev_reg - idx;
    assign dist_next    = (idx > next_marker_reg) ? idx - next_marker_reg
                                                  : next_marker_reg - idx;
    assign stamp        = {1'b0, tow10_reg} + {{4{diff_reg[32]}}, diff_reg};

    // read commands wait for a free output register
    assign q_pop = (state_reg == ST_IDLE) && q_valid &&
                   ((q_item.op != ltpps_pkg::OP_READ) || !out_valid_reg);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        line_count_next   = line_count_reg;
        marker_count_next = marker_count_reg;
        read_index_next   = read_index_reg;
        marker_pos_next   = marker_pos_reg;
        prev_next         = prev_reg;
        next_marker_next  = next_marker_reg;
        overflow_next     = overflow_reg;
        first_next        = first_reg;
        ref_next          = ref_reg;
        internal_next     = internal_reg;
        tow10_next        = tow10_reg;
        diff_next         = diff_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_next          = out_reg;
        line_we           = 1'b0;
        line_waddr        = line_count_reg[IW-1:0];
        line_wdata        = q_item.rec;
        line_re           = 1'b0;
        line_raddr        = idx;
        mk_we             = 1'b0;
        mk_waddr          = marker_count_reg[IW-1:0];
        mk_wdata          = line_count_reg[IW-1:0];
        mk_re             = 1'b0;
        mk_raddr          = marker_pos_reg + IW'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_item.op)
                        ltpps_pkg::OP_CLEAR:
                        begin
                            line_count_next   = '0;
                            marker_count_next = '0;
                            read_index_next   = '0;
                            marker_pos_next   = '0;
                            prev_next         = '0;
                            next_marker_next  = '0;
                            overflow_next     = 1'b0;
                        end
                        ltpps_pkg::OP_LOAD:
                        begin
                            if (line_count_reg == CW'(ltpps_pkg::MAX_LINES))
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                line_we         = 1'b1;
                                line_count_next = line_count_reg + CW'(1);
                                if (q_item.marker)
                                begin
                                    mk_we             = 1'b1;
                                    marker_count_next = marker_count_reg + CW'(1);
                                end
                            end
                        end
                        ltpps_pkg::OP_READ:
                        begin
                            out_next.timestamp  = '0;
                            out_next.is_last    = 1'b0;
                            out_next.overflowed = overflow_reg;
                            if (marker_count_reg == '0)
                            begin
                                out_next.status = ltpps_pkg::STAT_NO_MARKER;
                                out_valid_next  = 1'b1;
                            end
                            else if (read_index_reg >= line_count_reg)
                            begin
                                out_next.status = ltpps_pkg::STAT_EMPTY;
                                out_valid_next  = 1'b1;
                            end
                            else if (read_index_reg == '0)
                            begin
                                marker_pos_next = '0;
                                mk_re           = 1'b1;
                                mk_raddr        = '0;
                                first_next      = 1'b1;
                                state_next      = ST_MARK_A;
                            end
                            else if (({1'b0, next_marker_reg} < read_index_reg) &&
                                     more_markers)
                            begin
                                marker_pos_next = marker_pos_reg + IW'(1);
                                mk_re           = 1'b1;
                                first_next      = 1'b0;
                                state_next      = ST_MARK_A;
                            end
                            else
                            begin
                                state_next = ST_SEL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            // marker index arrives before the reference is chosen
            ST_MARK_A:
            begin
                next_marker_next = mk_rdata;
                if (first_reg)
                begin
                    prev_next = mk_rdata;
                end
                state_next = ST_SEL;
            end
            // nearest marker, the later one on a tie
            ST_SEL:
            begin
                ref_next   = (dist_prev < dist_next) ? prev_reg : next_marker_reg;
                line_re    = 1'b1;
                line_raddr = idx;
                state_next = ST_LINE_I;
            end
            ST_LINE_I:
            begin
                internal_next = line_rd.internal;
                line_re       = 1'b1;
                line_raddr    = ref_reg;
                state_next    = ST_LINE_R;
            end
            // week time times ten by shift and add
            ST_LINE_R:
            begin
                tow10_next = {1'b0, line_rd.tow, 3'b000} + {3'b000, line_rd.tow, 1'b0};
                diff_next  = {1'b0, internal_reg} - {1'b0, line_rd.pps};
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                out_next.timestamp  = signed'(stamp);
                out_next.is_last    = ((read_index_reg + CW'(1)) == line_count_reg);
                out_next.status     = ltpps_pkg::STAT_OK;
                out_next.overflowed = overflow_reg;
                out_valid_next      = 1'b1;
                read_index_next     = read_index_reg + CW'(1);
                state_next          = ST_IDLE;
                if (idx == next_marker_reg)
                begin
                    prev_next = next_marker_reg;
                    if (more_markers)
                    begin
                        marker_pos_next = marker_pos_reg + IW'(1);
                        mk_re           = 1'b1;
                        state_next      = ST_MARK_B;
                    end
                end
            end
            ST_MARK_B:
            begin
                next_marker_next = mk_rdata;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            line_count_reg   <= '0;
            marker_count_reg <= '0;
            read_index_reg   <= '0;
            marker_pos_reg   <= '0;
            prev_reg         <= '0;
            next_marker_reg  <= '0;
            overflow_reg     <= 1'b0;
            first_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            line_count_reg   <= line_count_next;
            marker_count_reg <= marker_count_next;
            read_index_reg   <= read_index_next;
            marker_pos_reg   <= marker_pos_next;
            prev_reg         <= prev_next;
            next_marker_reg  <= next_marker_next;
            overflow_reg     <= overflow_next;
            first_reg        <= first_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ref_reg      <= ref_next;
        internal_reg <= internal_next;
        tow10_reg    <= tow10_next;
        diff_reg     <= diff_next;
        out_reg      <= out_next;
    end

    // line store
    ltpps_ram #(
        .WIDTH (ltpps_pkg::REC_W),
        .DEPTH (ltpps_pkg::MAX_LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // marker list
    ltpps_ram #(
        .WIDTH (ltpps_pkg::IDX_W),
        .DEPTH (ltpps_pkg::MAX_LINES)
    ) u_marker_ram (
        .clk   (clk),
        .we    (mk_we),
        .waddr (mk_waddr),
        .wdata (mk_wdata),
        .re    (mk_re),
        .raddr (mk_raddr),
        .rdata (mk_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ src/line_timestamp_from_pps_markers.sv @@
// ----------------------------------------------------------------------------
// line_timestamp_from_pps_markers: per-line time stamps from PPS marker lines
// Stores line headers and returns one rebuilt time stamp or status per read command.
// ----------------------------------------------------------------------------
// Usage:
// - in channel (valid/ready) carries clear, load and read commands; each
//   item goes through a two-entry queue, so the sender keeps going while
//   the back end is busy. Command 3 is accepted and ignored.
// - out channel (valid/ready) gives one item per read command, in order.
// - a load writes the line store (and the marker list for a marker line).
// - a read may fetch a marker (pointer set or stepping before the stamp),
//   then picks the reference, reads the line store twice (the line, then
//   its reference marker), builds the stamp and, when the pointer steps after
//   it, fetches the next marker; both stores are synchronous RAMs with one read port each.
// - load, clear and status-only reads (no marker, nothing left) are done in the idle state.
// - a read waits in the queue until the output register is free, so a
//   stalled receiver holds back the reads, then the queue, then in_ready.
// - reset empties the store, counters and overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module line_timestamp_from_pps_markers (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ltpps_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ltpps_pkg::out_item_t out_data
);

    logic               q_valid;
    logic               q_pop;
    ltpps_pkg::q_item_t q_item;

    // accept and classify
    ltpps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // execute against the stores
    ltpps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ src/ltpps_checker.sv @@
// ----------------------------------------------------------------------------
// ltpps_checker: port-level checks for the line time stamp block
// Watches both channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module ltpps_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input ltpps_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input ltpps_pkg::out_item_t out_data
);

    // a waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input item changed or dropped while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // status-only results carry no stamp
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ltpps_pkg::STAT_OK) |->
        (out_data.timestamp == '0) && !out_data.is_last)
        else $error("status result carries stamp fields");

    // no result item is shown while reset is held
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a status beyond the defined codes never appears
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ltpps_pkg::STAT_OK) ||
                      (out_data.status == ltpps_pkg::STAT_NO_MARKER) ||
                      (out_data.status == ltpps_pkg::STAT_EMPTY))
        else $error("undefined status code");

endmodule

bind line_timestamp_from_pps_markers ltpps_checker u_ltpps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
